@@ hw/rtl/tefa_pkg.sv @@
// ----------------------------------------------------------------------------
// tefa_pkg
// types, constants and codes shared by the extent allocator modules
// ----------------------------------------------------------------------------
package tefa_pkg;

	localparam int SLOTS      = 128;
	localparam int TAPE_SIZE  = 512;
	localparam int BLK_W      = 9;
	localparam int SLOT_W     = 7;
	localparam int CELL_IDX_W = ($clog2(SLOTS) > SLOT_W) ? $clog2(SLOTS) : SLOT_W;
	localparam int CFG_IDX_W  = 2;

	localparam logic [BLK_W-1:0] UPPER_START_RST = BLK_W'(280);
	localparam logic [BLK_W-1:0] UPPER_END_RST   = BLK_W'(511);
	localparam logic [BLK_W-1:0] LOWER_TOP_RST   = BLK_W'(184);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_ALLOC = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_NOFIT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_UPPER_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_TOP   = 2'd2;

	typedef struct packed {
		logic              func;
		logic [SLOT_W-1:0] slot;
		logic [BLK_W-1:0]  start_block;
		logic [BLK_W-1:0]  block_count;
		logic              present;
	} in_item_t;

	typedef struct packed {
		logic             status;
		logic [BLK_W-1:0] alloc_start;
	} out_item_t;

	// candidate token moving down the cell row
	typedef struct packed {
		logic             vld;
		logic             last;
		logic [BLK_W-1:0] cand;
		logic             ok;
	} tok_t;

	// table write broadcast to all cells
	typedef struct packed {
		logic                  en;
		logic [CELL_IDX_W-1:0] slot;
		logic [BLK_W-1:0]      start;
		logic [BLK_W-1:0]      len;
		logic                  pres;
	} wr_t;

endpackage

@@ hw/rtl/tape_extent_first_fit_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// tape_extent_first_fit_allocator_unit
// extent table with first-fit placement over a row of slot cells
// ----------------------------------------------------------------------------
// write transaction: result in the cycle after acceptance, one write per cycle while the receiver takes each result
// allocate: candidates enter the SLOTS-cell row one per cycle; an upward pass, then a downward pass
//   when the length fits under the lower top, then an end token that brings the no-fit verdict
// one transaction at a time; a new one is taken once the result register is empty
//   or is being read in that cycle
// reset: all slots empty, region registers at 280, 511 and 184
module tape_extent_first_fit_allocator_unit
	import tefa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [BLK_W-1:0]     cfg_data
);

	typedef enum logic {ST_IDLE, ST_SEARCH} state_t;
	typedef enum logic [1:0] {PH_UP, PH_DOWN, PH_END, PH_STOP} phase_t;

	state_t                state_q;
	phase_t                phase_q;
	logic [BLK_W-1:0]      gen_cand_q;
	logic [BLK_W-1:0]      req_len_q;
	logic [CELL_IDX_W-1:0] req_slot_q;
	logic [BLK_W-1:0]      upper_start_q;
	logic [BLK_W-1:0]      upper_end_q;
	logic [BLK_W-1:0]      lower_top_q;
	logic                  out_valid_q;
	out_item_t             out_data_q;

	logic           in_acc;
	logic [BLK_W:0] cand_sum;
	logic           up_more;
	tok_t           tok_inj;
	tok_t           tok_exit;
	wr_t            wr;
	logic           found;
	logic           nofit;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign cand_sum = {1'b0, gen_cand_q} + {1'b0, req_len_q};
	assign up_more  = cand_sum < {1'b0, upper_end_q};

	always_comb begin
		tok_inj      = '0;
		tok_inj.cand = gen_cand_q;
		tok_inj.ok   = (gen_cand_q != '0) && (32'(cand_sum) <= TAPE_SIZE);
		if (state_q == ST_SEARCH) begin
			case (phase_q)
				PH_UP:   tok_inj.vld = up_more;
				PH_DOWN: tok_inj.vld = (gen_cand_q != '0);
				PH_END: begin
					tok_inj.vld  = 1'b1;
					tok_inj.last = 1'b1;
				end
				default: tok_inj.vld = 1'b0;
			endcase
		end
	end

	assign found = (state_q == ST_SEARCH) && tok_exit.vld && !tok_exit.last && tok_exit.ok;
	assign nofit = (state_q == ST_SEARCH) && tok_exit.vld && tok_exit.last;

	always_comb begin
		wr = '0;
		if (in_acc && (in_data.func == FUNC_WRITE)) begin
			wr.en    = 1'b1;
			wr.slot  = CELL_IDX_W'(in_data.slot);
			wr.start = in_data.start_block;
			wr.len   = in_data.block_count;
			wr.pres  = in_data.present;
		end else if (found) begin
			wr.en    = 1'b1;
			wr.slot  = req_slot_q;
			wr.start = tok_exit.cand;
			wr.len   = req_len_q;
			wr.pres  = 1'b1;
		end
	end

	tefa_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.flush   (found),
		.req_len (req_len_q),
		.skip    (req_slot_q),
		.tok_in  (tok_inj),
		.tok_out (tok_exit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_STOP;
			gen_cand_q    <= '0;
			req_len_q     <= '0;
			req_slot_q    <= '0;
			upper_start_q <= UPPER_START_RST;
			upper_end_q   <= UPPER_END_RST;
			lower_top_q   <= LOWER_TOP_RST;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_UPPER_START: upper_start_q <= cfg_data;
					REG_UPPER_END:   upper_end_q   <= cfg_data;
					REG_LOWER_TOP:   lower_top_q   <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_data.func == FUNC_WRITE) begin
							out_valid_q <= 1'b1;
							out_data_q  <= '{status: STATUS_OK, alloc_start: '0};
						end else if (32'(in_data.slot) >= SLOTS) begin
							out_valid_q <= 1'b1;
							out_data_q  <= '{status: STATUS_NOFIT, alloc_start: '0};
						end else begin
							state_q    <= ST_SEARCH;
							phase_q    <= PH_UP;
							gen_cand_q <= upper_start_q;
							req_len_q  <= in_data.block_count;
							req_slot_q <= CELL_IDX_W'(in_data.slot);
						end
					end
				end
				ST_SEARCH: begin
					if (found) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_data_q  <= '{status: STATUS_OK, alloc_start: tok_exit.cand};
					end else if (nofit) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_data_q  <= '{status: STATUS_NOFIT, alloc_start: '0};
					end

					case (phase_q)
						PH_UP: begin
							if (up_more) begin
								gen_cand_q <= gen_cand_q + 1'b1;
							end else if (req_len_q <= lower_top_q) begin
								phase_q    <= PH_DOWN;
								gen_cand_q <= lower_top_q - req_len_q;
							end else begin
								phase_q <= PH_END;
							end
						end
						PH_DOWN: begin
							if (gen_cand_q != '0) begin
								gen_cand_q <= gen_cand_q - 1'b1;
							end else begin
								phase_q <= PH_END;
							end
						end
						PH_END:  phase_q <= PH_STOP;
						default: phase_q <= PH_STOP;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/tefa_cell.sv @@
// ----------------------------------------------------------------------------
// tefa_cell
// one table slot: holds an extent and checks each passing candidate against it
// ----------------------------------------------------------------------------
module tefa_cell
	import tefa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CELL_IDX_W-1:0] idx,
	input  wr_t                   wr,
	input  logic                  flush,
	input  logic [BLK_W-1:0]      req_len,
	input  logic [CELL_IDX_W-1:0] skip,
	input  tok_t                  tok_in,
	output tok_t                  tok_out
);

	logic [BLK_W-1:0] ext_start_q;
	logic [BLK_W-1:0] ext_len_q;
	logic             ext_pres_q;
	logic             tok_vld_q;
	logic             tok_last_q;
	logic [BLK_W-1:0] tok_cand_q;
	logic             tok_ok_q;

	logic [BLK_W:0] cand_end;
	logic [BLK_W:0] ext_end;
	logic           hit;
	logic           wr_here;

	assign wr_here  = wr.en && (wr.slot == idx);
	assign cand_end = {1'b0, tok_in.cand} + {1'b0, req_len};
	assign ext_end  = {1'b0, ext_start_q} + {1'b0, ext_len_q};
	assign hit      = ext_pres_q && (idx != skip) &&
		(cand_end > {1'b0, ext_start_q}) && ({1'b0, tok_in.cand} < ext_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_pres_q <= 1'b0;
			tok_vld_q  <= 1'b0;
		end else begin
			if (wr_here) begin
				ext_pres_q <= wr.pres;
			end
			tok_vld_q <= tok_in.vld && !flush;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_here) begin
			ext_start_q <= wr.start;
			ext_len_q   <= wr.len;
		end
		tok_last_q <= tok_in.last;
		tok_cand_q <= tok_in.cand;
		tok_ok_q   <= tok_in.ok && !hit;
	end

	assign tok_out.vld  = tok_vld_q;
	assign tok_out.last = tok_last_q;
	assign tok_out.cand = tok_cand_q;
	assign tok_out.ok   = tok_ok_q;

endmodule

@@ hw/rtl/tefa_chain.sv @@
// ----------------------------------------------------------------------------
// tefa_chain
// row of slot cells, candidates pass one cell per cycle
// ----------------------------------------------------------------------------
module tefa_chain
	import tefa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  wr_t                   wr,
	input  logic                  flush,
	input  logic [BLK_W-1:0]      req_len,
	input  logic [CELL_IDX_W-1:0] skip,
	input  tok_t                  tok_in,
	output tok_t                  tok_out
);

	tok_t tok [0:SLOTS];

	assign tok[0]  = tok_in;
	assign tok_out = tok[SLOTS];

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		tefa_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (CELL_IDX_W'(k)),
			.wr      (wr),
			.flush   (flush),
			.req_len (req_len),
			.skip    (skip),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tape extent first-fit allocator: a queue-fed
// driver sends slot writes and allocations, a local model of the extent table
// predicts each status and start, and a monitor checks every result in order
// across several region register settings, with random gaps and one long
// receiver hold-off
// ----------------------------------------------------------------------------
module tb_top;
	import tefa_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_AT     = 45;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [BLK_W-1:0] start;
		logic [BLK_W-1:0] length;
		logic             present;
	} extent_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [BLK_W-1:0]     cfg_data;

	extent_rec_t      extent_tbl [SLOTS];
	logic [BLK_W-1:0] reg_upper_start;
	logic [BLK_W-1:0] reg_upper_end;
	logic [BLK_W-1:0] reg_lower_top;

	in_item_t  tape_ops_q [$];
	out_item_t alloc_verdicts_q [$];
	out_item_t want;

	bit no_gaps = 1'b0;
	bit hold_done;
	int hold_left;
	int results_seen;
	int errors = 0;
	int stall_cycles;

	tape_extent_first_fit_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// true when c is nonzero, c+n fits the tape and blocks c .. c+n-1 are free of every other present extent
	function automatic bit span_free(int c, int n, int skip);
		if (c == 0 || c + n > TAPE_SIZE)
			return 1'b0;
		for (int k = 0; k < SLOTS; k++) begin
			if (k != skip && extent_tbl[k].present &&
			    c + n > int'(extent_tbl[k].start) &&
			    c < int'(extent_tbl[k].start) + int'(extent_tbl[k].length))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic out_item_t run_tape_op(in_item_t op);
		out_item_t r;
		int        c;
		int        n;
		bit        hit;
		r = '0;
		r.status = STATUS_OK;
		if (op.func == FUNC_WRITE) begin
			if (int'(op.slot) < SLOTS)
				extent_tbl[op.slot] = '{op.start_block, op.block_count, op.present};
			return r;
		end
		if (int'(op.slot) >= SLOTS) begin
			r.status = STATUS_NOFIT;
			return r;
		end
		n = int'(op.block_count);
		hit = 1'b0;
		c = int'(reg_upper_start);
		while (!hit && c + n < int'(reg_upper_end)) begin
			if (span_free(c, n, int'(op.slot)))
				hit = 1'b1;
			else
				c++;
		end
		if (!hit && n <= int'(reg_lower_top)) begin
			c = int'(reg_lower_top) - n;
			while (!hit && c > 0) begin
				if (span_free(c, n, int'(op.slot)))
					hit = 1'b1;
				else
					c--;
			end
		end
		if (hit) begin
			extent_tbl[op.slot] = '{c[BLK_W-1:0], op.block_count, 1'b1};
			r.alloc_start = c[BLK_W-1:0];
		end else begin
			r.status = STATUS_NOFIT;
		end
		return r;
	endfunction

	task automatic push_op(logic func, int slot, int sb, int cnt, logic pres);
		in_item_t op;
		op.func        = func;
		op.slot        = slot[SLOT_W-1:0];
		op.start_block = sb[BLK_W-1:0];
		op.block_count = cnt[BLK_W-1:0];
		op.present     = pres;
		tape_ops_q.push_back(op);
	endtask

	task automatic random_ops(int count);
		in_item_t op;
		repeat (count) begin
			op.func        = ($urandom_range(99) < 35) ? FUNC_WRITE : FUNC_ALLOC;
			op.slot        = ($urandom_range(3) == 0) ? SLOT_W'($urandom_range(127)) :
			                 SLOT_W'($urandom_range(15));
			op.start_block = BLK_W'($urandom_range(511));
			op.block_count = ($urandom_range(9) == 0) ? BLK_W'($urandom_range(511)) :
			                 BLK_W'($urandom_range(40));
			op.present     = ($urandom_range(4) != 0);
			tape_ops_q.push_back(op);
		end
	endtask

	task automatic write_region(logic [CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val[BLK_W-1:0];
		case (idx)
			REG_UPPER_START: reg_upper_start = val[BLK_W-1:0];
			REG_UPPER_END:   reg_upper_end   = val[BLK_W-1:0];
			REG_LOWER_TOP:   reg_lower_top   = val[BLK_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regions(int up_start, int up_end, int low_top);
		write_region(REG_UPPER_START, up_start);
		write_region(REG_UPPER_END, up_end);
		write_region(REG_LOWER_TOP, low_top);
	endtask

	task automatic drain();
		while (tape_ops_q.size() != 0 || in_valid || alloc_verdicts_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// driver: predict on acceptance, then offer the next transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else begin
			if (in_valid && in_ready)
				alloc_verdicts_q.push_back(run_tape_op(in_data));
			if (!in_valid || in_ready) begin
				if (tape_ops_q.size() != 0 && (no_gaps || $urandom_range(99) >= 8)) begin
					in_valid <= 1'b1;
					in_data  <= tape_ops_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result, random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready    <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
			results_seen <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (alloc_verdicts_q.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual status=%0d start=%0d",
						$time, out_data.status, out_data.alloc_start);
					errors++;
				end else begin
					want = alloc_verdicts_q.pop_front();
					if (out_data.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.status, out_data.status);
						errors++;
					end
					if (out_data.alloc_start !== want.alloc_start) begin
						$display("%0t: alloc_start mismatch, expected %0d, actual %0d",
							$time, want.alloc_start, out_data.alloc_start);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (results_seen == HOLD_AT && !hold_done) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_gaps || ($urandom_range(99) >= 8);
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		cfg_we   = 1'b0;
		cfg_idx  = '0;
		cfg_data = '0;
		for (int k = 0; k < SLOTS; k++)
			extent_tbl[k] = '{'0, '0, 1'b0};
		reg_upper_start = UPPER_START_RST;
		reg_upper_end   = UPPER_END_RST;
		reg_lower_top   = LOWER_TOP_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, zero lengths, absent extents, own slot,
		// skipped lower pass, lower pass running down to block zero
		push_op(FUNC_WRITE, 0, 0, 0, 1'b0);
		push_op(FUNC_WRITE, 127, 511, 511, 1'b1);
		push_op(FUNC_WRITE, 5, 300, 0, 1'b1);
		push_op(FUNC_WRITE, 6, 280, 10, 1'b0);
		push_op(FUNC_ALLOC, 1, 511, 10, 1'b1);
		push_op(FUNC_ALLOC, 2, 0, 0, 1'b0);
		push_op(FUNC_ALLOC, 1, $urandom_range(511), 20, 1'b1);
		push_op(FUNC_ALLOC, 3, $urandom_range(511), 511, 1'b0);
		push_op(FUNC_ALLOC, 4, $urandom_range(511), 200, 1'b1);
		push_op(FUNC_ALLOC, 7, $urandom_range(511), 184, 1'b0);
		push_op(FUNC_WRITE, 10, 280, 231, 1'b1);
		push_op(FUNC_ALLOC, 11, $urandom_range(511), 183, 1'b1);
		push_op(FUNC_ALLOC, 12, $urandom_range(511), 5, 1'b0);
		push_op(FUNC_WRITE, 11, 0, 0, 1'b0);
		push_op(FUNC_ALLOC, 13, $urandom_range(511), 0, 1'b1);
		push_op(FUNC_WRITE, 20, 170, 14, 1'b1);
		push_op(FUNC_ALLOC, 21, $urandom_range(511), 20, 1'b0);
		push_op(FUNC_WRITE, 64, 'h155, 'h0AA, 1'b1);
		push_op(FUNC_WRITE, 127, 'h0AA, 'h155, 1'b1);
		push_op(FUNC_ALLOC, 127, $urandom_range(511), 1, 1'b1);
		push_op(FUNC_WRITE, 10, 0, 0, 1'b0);
		push_op(FUNC_ALLOC, 22, $urandom_range(511), 40, 1'b0);
		random_ops(30);
		drain();

		no_gaps = 1'b1;
		set_regions(0, 511, 511);
		random_ops(16);
		drain();
		no_gaps = 1'b0;

		set_regions(511, 0, 0);
		random_ops(8);
		drain();

		set_regions(1, 300, 511);
		random_ops(12);
		drain();

		set_regions(400, 511, 60);
		random_ops(12);
		drain();

		repeat (SLOTS + 16) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/tefa_pkg.sv
hw/rtl/tefa_cell.sv
hw/rtl/tefa_chain.sv
hw/rtl/tape_extent_first_fit_allocator_unit.sv
tb/tb_top.sv
